// ===== design/pee_pkg.sv =====
// shared types and constants of the postfix expression evaluator
`default_nettype none
package pee_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW          = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;

    localparam logic [31:0] VALUE_ERR = 32'hFFFF_FFFF;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_COUNT = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_DIVZ  = 3'd3;
    localparam logic [2:0] ST_OVER  = 3'd4;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_MUL,
        OP_DIV,
        OP_ADD,
        OP_SUB
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] imm;
        logic        last;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXE,
        S_DIV,
        S_FRD,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== design/pee_if.sv =====
// stream interfaces for the character input and the result output
`default_nettype none
interface pee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_last;

    modport source (output valid, output ch, output is_last, input ready);
    modport sink   (input valid, input ch, input is_last, output ready);
endinterface

interface pee_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [2:0]  status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

// ===== design/pee_front.sv =====
// front end: takes characters and classifies them into stack commands
`default_nettype none
module pee_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pee_in_if.sink           i_in,
    output pee_pkg::t_cmd    o_cmd,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_ready
);
    import pee_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign i_in.ready = !r_valid || i_cmd_ready;

    always_comb begin
        n_cmd.imm  = 32'(i_in.ch) - 32'(CH_ZERO);
        n_cmd.last = i_in.is_last;
        unique case (i_in.ch)
            CH_MUL:  n_cmd.op = OP_MUL;
            CH_DIV:  n_cmd.op = OP_DIV;
            CH_ADD:  n_cmd.op = OP_ADD;
            CH_SUB:  n_cmd.op = OP_SUB;
            default: n_cmd.op = OP_PUSH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd       = r_cmd;
    assign o_cmd_valid = r_valid;

endmodule
`default_nettype wire

// ===== design/pee_queue.sv =====
// two-entry command queue between front end and execution unit
`default_nettype none
module pee_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pee_pkg::t_cmd i_cmd,
    input  wire logic          i_valid,
    output logic               o_ready,
    output pee_pkg::t_cmd      o_cmd,
    output logic               o_valid,
    input  wire logic          i_ready
);
    import pee_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== design/pee_divider.sv =====
// radix-2 restoring divider for unsigned 32-bit magnitudes
`default_nettype none
module pee_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    assign rem_sh = {r_rem, r_quo[31]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'd0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], !diff[32]};
            r_rem <= diff[32] ? rem_sh[31:0] : diff[31:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

// ===== design/pee_back.sv =====
// execution unit: operand stack memory, arithmetic and result register
`default_nettype none
module pee_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pee_pkg::t_cmd i_cmd,
    input  wire logic          i_valid,
    output logic               o_ready,
    pee_out_if.source          o_out
);
    import pee_pkg::*;

    logic [31:0] r_stack [STACK_DEPTH];

    t_state      r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [2:0]  r_err, n_err;
    t_op         r_op, n_op;
    logic        r_last, n_last;
    logic        r_neg, n_neg;
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_value, n_out_value;
    logic [2:0]  r_out_status, n_out_status;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic [31:0]   mul_res;
    logic [31:0]   mag_l;
    logic [31:0]   mag_r;
    logic          div_start;
    logic          div_done;
    logic [31:0]   div_q;

    assign cnt_m1  = r_count - CW'(1);
    assign cnt_m2  = r_count - CW'(2);
    assign mul_res = r_rd_b * r_rd_a;
    assign mag_l   = r_rd_b[31] ? (32'd0 - r_rd_b) : r_rd_b;
    assign mag_r   = r_rd_a[31] ? (32'd0 - r_rd_a) : r_rd_a;

    pee_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mag_l),
        .i_divisor  (mag_r),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // operand memory, top two entries read every cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_stack[cnt_m1[AW-1:0]];
        r_rd_b <= r_stack[cnt_m2[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_last       <= n_last;
        r_neg        <= n_neg;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_err        = r_err;
        n_op         = r_op;
        n_last       = r_last;
        n_neg        = r_neg;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_wa       = r_count[AW-1:0];
        mem_wd       = i_cmd.imm;
        div_start    = 1'b0;
        o_ready      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op    = i_cmd.op;
                    n_last  = i_cmd.last;
                    n_state = i_cmd.last ? S_FRD : S_IDLE;
                    if (r_err != ST_OK) begin
                        // rest of a failed expression is dropped
                    end else if (i_cmd.op == OP_PUSH) begin
                        if (r_count == CW'(STACK_DEPTH)) begin
                            n_err = ST_OVER;
                        end else begin
                            mem_we  = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count < CW'(2)) begin
                        n_err = ST_UNDER;
                    end else begin
                        n_state = S_EXE;
                    end
                end
            end
            S_EXE: begin
                mem_wa  = cnt_m2[AW-1:0];
                n_state = r_last ? S_FRD : S_IDLE;
                unique case (r_op)
                    OP_MUL: begin
                        mem_we  = 1'b1;
                        mem_wd  = mul_res;
                        n_count = cnt_m1;
                    end
                    OP_ADD: begin
                        mem_we  = 1'b1;
                        mem_wd  = r_rd_b + r_rd_a;
                        n_count = cnt_m1;
                    end
                    OP_SUB: begin
                        mem_we  = 1'b1;
                        mem_wd  = r_rd_b - r_rd_a;
                        n_count = cnt_m1;
                    end
                    OP_DIV: begin
                        if (r_rd_a == 32'd0) begin
                            n_err   = ST_DIVZ;
                            n_count = cnt_m2;
                        end else begin
                            div_start = 1'b1;
                            n_neg     = r_rd_b[31] ^ r_rd_a[31];
                            n_state   = S_DIV;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                mem_wa = cnt_m2[AW-1:0];
                mem_wd = r_neg ? (32'd0 - div_q) : div_q;
                if (div_done) begin
                    mem_we  = 1'b1;
                    n_count = cnt_m1;
                    n_state = r_last ? S_FRD : S_IDLE;
                end
            end
            S_FRD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    if (r_err != ST_OK) begin
                        n_out_value  = VALUE_ERR;
                        n_out_status = r_err;
                    end else if (r_count != CW'(1)) begin
                        n_out_value  = VALUE_ERR;
                        n_out_status = ST_COUNT;
                    end else begin
                        n_out_value  = r_rd_a;
                        n_out_status = ST_OK;
                    end
                    n_count = '0;
                    n_err   = ST_OK;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.value  = r_out_value;
    assign o_out.status = r_out_status;

endmodule
`default_nettype wire

// ===== design/postfix_expression_evaluator_core.sv =====
// top level of the postfix expression evaluator
//
//  channel | dir | payload                        | transfer
//  --------+-----+--------------------------------+------------------------
//  i_in    | in  | ch[7:0], is_last               | valid && ready
//  o_out   | out | value[31:0] signed, status[2:0] | valid && ready, last char
//
// steps: a digit is pushed in idle, * + - pass the execute state, a / with
// a nonzero divisor also waits in the divide state on the bit-serial divider;
// a final character then reads the stack bottom and loads the result register
// the front end register and the two-entry queue keep taking characters while
// the execution unit is busy, until full, so divides set the rate
// reset: synchronous, active low; clears stack count, error code and all
// valid flags, the stack memory itself is never cleared
// a stalled result register holds the execution unit in its output state
`default_nettype none
module postfix_expression_evaluator_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pee_in_if.sink    i_in,
    pee_out_if.source o_out
);
    import pee_pkg::*;

    // front end to queue
    t_cmd f_cmd;
    logic f_valid;
    logic f_ready;

    // queue to execution unit
    t_cmd b_cmd;
    logic b_valid;
    logic b_ready;

    // classify each character into a push or an arithmetic command
    pee_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (f_cmd),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready)
    );

    // decouples character intake from long divide operations
    pee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (f_cmd),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .o_cmd   (b_cmd),
        .o_valid (b_valid),
        .i_ready (b_ready)
    );

    // stack, arithmetic, error tracking and result register
    pee_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (b_cmd),
        .i_valid (b_valid),
        .o_ready (b_ready),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

// ===== sim/postfix_expression_evaluator_core_test.sv =====
// self-checking testbench of the postfix expression evaluator core
`timescale 1ns / 100ps
module postfix_expression_evaluator_core_test;
    import pee_pkg::*;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [2:0]  status;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pee_in_if  chars ();
    pee_out_if results ();

    postfix_expression_evaluator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (chars),
        .o_out   (results)
    );

    always #10 i_clk = ~i_clk;

    // evaluator state as predicted from the accepted characters
    logic [31:0]  calc_stack [STACK_DEPTH];
    int unsigned  calc_depth = 0;
    logic [2:0]   calc_err   = ST_OK;
    t_result      expected_results [$];

    bit           gaps_on     = 1'b1;
    bit           stalls_on   = 1'b1;
    int unsigned  hold_cycles = 0;
    int unsigned  live_chars  = 0;
    int unsigned  mismatches  = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic bit is_operator(input logic [7:0] c);
        return c == CH_MUL || c == CH_DIV || c == CH_ADD || c == CH_SUB;
    endfunction

    // signed division truncated toward zero, done on magnitudes so that
    // the most negative value over minus one wraps instead of trapping
    function automatic logic [31:0] quot_toward_zero(input logic [31:0] lhs,
                                                     input logic [31:0] rhs);
        logic [31:0] ml, mr, q;
        ml = lhs[31] ? 32'd0 - lhs : lhs;
        mr = rhs[31] ? 32'd0 - rhs : rhs;
        q  = ml / mr;
        return (lhs[31] != rhs[31]) ? 32'd0 - q : q;
    endfunction

    task automatic push_operand(input logic [31:0] v);
        if (calc_depth >= STACK_DEPTH) begin
            calc_err = ST_OVER;
        end else begin
            calc_stack[AW'(calc_depth)] = v;
            calc_depth++;
        end
    endtask

    task automatic evaluate_char(input logic [7:0] c, input logic last);
        logic [31:0] lhs, rhs, res;
        bit          keep;
        t_result     r;
        if (calc_err == ST_OK || last)
            live_chars++;
        if (calc_err == ST_OK) begin
            if (!is_operator(c)) begin
                push_operand({24'd0, c} - {24'd0, CH_ZERO});
            end else if (calc_depth < 2) begin
                calc_err = ST_UNDER;
            end else begin
                rhs  = calc_stack[AW'(calc_depth - 1)];
                lhs  = calc_stack[AW'(calc_depth - 2)];
                calc_depth -= 2;
                keep = 1'b1;
                res  = '0;
                case (c)
                    CH_MUL: res = lhs * rhs;
                    CH_ADD: res = lhs + rhs;
                    CH_SUB: res = lhs - rhs;
                    default: begin
                        // both operands stay popped on a zero divisor
                        if (rhs == 32'd0) begin
                            calc_err = ST_DIVZ;
                            keep     = 1'b0;
                        end else begin
                            res = quot_toward_zero(lhs, rhs);
                        end
                    end
                endcase
                if (keep)
                    push_operand(res);
            end
        end
        if (last) begin
            if (calc_err != ST_OK) begin
                r.value  = VALUE_ERR;
                r.status = calc_err;
            end else if (calc_depth != 1) begin
                r.value  = VALUE_ERR;
                r.status = ST_COUNT;
            end else begin
                r.value  = calc_stack[0];
                r.status = ST_OK;
            end
            expected_results.push_back(r);
            calc_depth = 0;
            calc_err   = ST_OK;
        end
    endtask

    // called only in a step right after a rising edge; valid stays high
    // after the transfer so that a following character goes back to back
    task automatic send_char(input logic [7:0] c, input logic last);
        int unsigned gap;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            chars.valid <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(posedge i_clk);
        end
        chars.valid   <= 1'b1;
        chars.ch      <= c;
        chars.is_last <= last;
        @(posedge i_clk);
        while (!chars.ready) @(posedge i_clk);
        evaluate_char(c, last);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_operator();
        int unsigned k;
        k = $urandom_range(0, 15);
        // keep divisions rare, each one costs the full divider latency
        if (k < 2)
            return CH_DIV;
        else if (k < 7)
            return CH_MUL;
        else if (k < 11)
            return CH_ADD;
        else
            return CH_SUB;
    endfunction

    function automatic logic [7:0] pick_operand();
        logic [7:0] c;
        if ($urandom_range(0, 7) != 0)
            return 8'($urandom_range(48, 57));
        do c = 8'($urandom_range(0, 255)); while (is_operator(c));
        return c;
    endfunction

    task automatic send_random_expression(input int unsigned n_operands);
        int unsigned depth, pushed;
        logic [7:0]  c;
        depth  = 0;
        pushed = 0;
        while (pushed < n_operands || depth > 1) begin
            if (depth >= 2 && (pushed == n_operands || $urandom_range(0, 2) == 0)) begin
                c = pick_operator();
                depth--;
            end else begin
                c = pick_operand();
                pushed++;
                depth++;
            end
            send_char(c, pushed == n_operands && depth == 1);
        end
    endtask

    // arbitrary bytes with scattered final flags, always closed by a final one
    task automatic send_noise(input int unsigned n);
        for (int i = 0; i < n; i++)
            send_char(8'($urandom_range(0, 255)),
                      i == n - 1 || $urandom_range(0, 4) == 0);
    endtask

    task automatic wait_drained(input int unsigned settle);
        chars.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic test_arithmetic();
        // 2-7 = -5, /3 = -1, *4 = -4, +9 = 5
        send_string("27-3/4*9+");
        send_string("93/");
    endtask

    task automatic test_input_extremes();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
    endtask

    task automatic test_error_codes();
        send_string("+5");   // underflow, then the rest is ignored
        send_string("50/");  // divide by zero
        send_string("34");   // two values left
    endtask

    task automatic test_most_negative_quotient();
        // 128^4 * 8 wraps to the most negative value, then / (0-1)
        send_char(8'd176, 1'b0);
        repeat (3) begin
            send_char(8'd176, 1'b0);
            send_char(CH_MUL, 1'b0);
        end
        send_char(CH_ZERO + 8'd8, 1'b0);
        send_char(CH_MUL, 1'b0);
        send_char(CH_ZERO, 1'b0);
        send_char(CH_ZERO + 8'd1, 1'b0);
        send_char(CH_SUB, 1'b0);
        send_char(CH_DIV, 1'b1);
    endtask

    task automatic test_stack_limits();
        // full stack reduced to one value
        repeat (STACK_DEPTH) send_char(8'($urandom_range(48, 57)), 1'b0);
        for (int i = 1; i < STACK_DEPTH; i++)
            send_char(pick_operator(), i == STACK_DEPTH - 1);
        // full stack left as is
        for (int i = 0; i < STACK_DEPTH; i++)
            send_char(8'($urandom_range(48, 57)), i == STACK_DEPTH - 1);
        // one push too many, the operators after it are ignored
        repeat (STACK_DEPTH + 1) send_char(8'($urandom_range(48, 57)), 1'b0);
        send_char(CH_ADD, 1'b0);
        send_char(CH_ADD, 1'b1);
    endtask

    task automatic test_output_backpressure();
        bit saved;
        saved       = gaps_on;
        gaps_on     = 1'b0;
        hold_cycles = 300;
        repeat (16) send_char(8'($urandom_range(48, 57)), 1'b1);
        gaps_on     = saved;
        wait_drained(4);
    endtask

    task automatic test_random_expressions();
        int unsigned goal, k;
        goal = live_chars + 1300;
        while (live_chars < goal) begin
            if ($urandom_range(0, 39) == 0) begin
                gaps_on   = 1'($urandom_range(0, 1));
                stalls_on = 1'($urandom_range(0, 1));
            end
            k = $urandom_range(0, 9);
            if (k < 7)
                send_random_expression($urandom_range(0, 15) == 0 ?
                                       $urandom_range(9, 40) : $urandom_range(1, 6));
            else
                send_noise($urandom_range(1, 8));
        end
    endtask

    task automatic test_back_to_back();
        int unsigned goal;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        goal      = live_chars + 150;
        while (live_chars < goal)
            send_random_expression($urandom_range(1, 6));
    endtask

    // result receiver: random stall bursts, plus one long hold on request
    initial begin
        int unsigned n;
        results.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
                results.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (stalls_on && $urandom_range(0, 5) == 0) begin
                results.ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(posedge i_clk);
            end else begin
                results.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (results.valid && results.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", results.value, 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (results.value !== want.value)
                    report_mismatch("value", results.value, want.value);
                if (results.status !== want.status)
                    report_mismatch("status", 32'(results.status), 32'(want.status));
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        chars.valid   <= 1'b0;
        chars.ch      <= 8'd0;
        chars.is_last <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_arithmetic();
        test_input_extremes();
        test_error_codes();
        test_most_negative_quotient();
        test_stack_limits();
        test_output_backpressure();
        test_random_expressions();
        test_back_to_back();

        // divider plus stack read and output register
        wait_drained(60);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("postfix_expression_evaluator_core_test OK");
        else
            $display("postfix_expression_evaluator_core_test NOT OK");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("postfix_expression_evaluator_core_test NOT OK");
        $finish;
    end

endmodule
